>>> rtl/sequence_window_loss_dup_checker_unit_assert.svh
// assertion macros used by the checker file of the sequence window checker
// no dependencies; include once per file that asserts
`ifndef SEQUENCE_WINDOW_LOSS_DUP_CHECKER_UNIT_ASSERT_SVH
`define SEQUENCE_WINDOW_LOSS_DUP_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SWLDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swldc assertion failed");

// next-cycle implication, quiet during reset
`define SWLDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swldc assertion failed");

`endif

>>> rtl/swldc_pkg.sv
// shared types and constants for the sequence window loss and duplicate checker
// no dependencies
package swldc_pkg;

  localparam int WINDOW_LOG2_DEFAULT = 5;
  localparam int SEQ_W = 32;
  localparam int CNT_W = 64;

  // largest forward distance still taken as a gap
  localparam logic [SEQ_W-1:0] HALF_RANGE = {1'b1, {(SEQ_W-1){1'b0}}};

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;   // load the word and restart the window scan
    logic step;    // issue the next window read, compare the previous one
    logic update;  // commit counters, window and result
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic hit;     // the compared window entry equals the word
    logic done;    // every valid entry has been compared
  } dp_status_t;

endpackage

>>> rtl/sequence_window_loss_dup_checker_unit.sv
// Sequence window loss and duplicate checker. Each input word is a 32-bit packet
// sequence number; each one yields exactly one result word with a duplicate flag,
// the gap revealed by evicting the oldest window entry, and three wrapping 64-bit
// totals. The window holds the last 2^WINDOW_LOG2 distinct numbers in a single-port
// read memory scanned one entry per cycle from the oldest, stopping early when a
// duplicate is found. One word is processed at a time; the next is taken while a
// finished result still waits at the output. No clearing pass is needed after reset.
module sequence_window_loss_dup_checker_unit #(
  parameter int WINDOW_LOG2 = swldc_pkg::WINDOW_LOG2_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [swldc_pkg::SEQ_W-1:0] seq_number,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        dup_flag,
  output logic                        gap_flag,
  output logic [swldc_pkg::SEQ_W-1:0] gap_start,
  output logic [swldc_pkg::SEQ_W-1:0] gap_end,
  output logic [swldc_pkg::CNT_W-1:0] duplicate_total,
  output logic [swldc_pkg::CNT_W-1:0] missing_total,
  output logic [swldc_pkg::CNT_W-1:0] original_total
);

  import swldc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencing
  swldc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // window, scan and counters
  swldc_datapath #(
    .WINDOW_LOG2 (WINDOW_LOG2)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .seq_number      (seq_number),
    .cmd             (cmd),
    .status          (status),
    .dup_flag        (dup_flag),
    .gap_flag        (gap_flag),
    .gap_start       (gap_start),
    .gap_end         (gap_end),
    .duplicate_total (duplicate_total),
    .missing_total   (missing_total),
    .original_total  (original_total)
  );

endmodule

>>> rtl/swldc_ram.sv
// generic single write port, single read port RAM with registered read data
// no dependencies
module swldc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/swldc_ctrl.sv
// controller state machine of the sequence window checker
// depends on swldc_pkg
module swldc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  swldc_pkg::dp_status_t  status,
  output swldc_pkg::ctrl_cmd_t   cmd
);

  import swldc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  // output register can take a new word this cycle
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (status.hit || status.done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output valid: set by a commit, cleared when taken
  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.update) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/swldc_datapath.sv
// datapath of the sequence window checker: window memory, scan, gap check, counters
// depends on swldc_pkg and swldc_ram
module swldc_datapath #(
  parameter int WINDOW_LOG2 = swldc_pkg::WINDOW_LOG2_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [swldc_pkg::SEQ_W-1:0] seq_number,
  input  swldc_pkg::ctrl_cmd_t        cmd,
  output swldc_pkg::dp_status_t       status,
  output logic                        dup_flag,
  output logic                        gap_flag,
  output logic [swldc_pkg::SEQ_W-1:0] gap_start,
  output logic [swldc_pkg::SEQ_W-1:0] gap_end,
  output logic [swldc_pkg::CNT_W-1:0] duplicate_total,
  output logic [swldc_pkg::CNT_W-1:0] missing_total,
  output logic [swldc_pkg::CNT_W-1:0] original_total
);

  import swldc_pkg::*;

  localparam int WIN_SIZE = 1 << WINDOW_LOG2;
  localparam logic [WINDOW_LOG2:0] WIN_FULL = (WINDOW_LOG2+1)'(WIN_SIZE);
  localparam logic [WINDOW_LOG2:0] IDX_OLDEST = '0;
  localparam logic [WINDOW_LOG2:0] IDX_SECOND = (WINDOW_LOG2+1)'(1);

  logic [SEQ_W-1:0]       seq_reg;
  logic [WINDOW_LOG2-1:0] oldest_slot;
  logic [WINDOW_LOG2:0]   fill_level;
  logic [WINDOW_LOG2:0]   scan_idx;
  logic [WINDOW_LOG2:0]   cmp_idx;
  logic                   cmp_valid;
  logic                   found;
  logic [SEQ_W-1:0]       oldest_entry;
  logic [SEQ_W-1:0]       second_entry;
  logic [SEQ_W-1:0]       rd_data;
  logic [WINDOW_LOG2-1:0] rd_addr;
  logic [WINDOW_LOG2-1:0] wr_addr;
  logic                   rd_en;
  logic                   wr_en;
  logic                   full;
  logic [SEQ_W-1:0]       diff;
  logic                   gap;

  // window memory
  swldc_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (WIN_SIZE)
  ) u_window (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (seq_reg),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // scan addressing, one read per cycle from the oldest entry onward
  assign rd_en   = cmd.step && (scan_idx < fill_level);
  assign rd_addr = oldest_slot + scan_idx[WINDOW_LOG2-1:0];

  // new entries go right after the newest one; when full this is the evicted slot
  assign wr_en   = cmd.update && !found;
  assign wr_addr = oldest_slot + fill_level[WINDOW_LOG2-1:0];

  // status to the controller
  assign status.hit  = cmp_valid && (rd_data == seq_reg);
  assign status.done = !cmp_valid && (scan_idx >= fill_level);

  // gap between the two oldest entries
  assign full = (fill_level == WIN_FULL);
  assign diff = second_entry - oldest_entry;
  assign gap  = full && (diff >= SEQ_W'(2)) && (diff <= HALF_RANGE);

  // scan pipeline
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      seq_reg   <= seq_number;
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.step) begin
      cmp_valid <= rd_en;
      cmp_idx   <= scan_idx;
      if (rd_en) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (status.hit) begin
        found <= 1'b1;
      end
      // keep the two oldest entries for the eviction check
      if (cmp_valid && (cmp_idx == IDX_OLDEST)) begin
        oldest_entry <= rd_data;
      end
      if (cmp_valid && (cmp_idx == IDX_SECOND)) begin
        second_entry <= rd_data;
      end
    end
  end

  // result word fields
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      dup_flag  <= found;
      gap_flag  <= !found && gap;
      gap_start <= (!found && gap) ? oldest_entry + 1'b1 : '0;
      gap_end   <= (!found && gap) ? second_entry - 1'b1 : '0;
    end
  end

  // window pointers and running counters
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_slot     <= '0;
      fill_level      <= '0;
      duplicate_total <= '0;
      missing_total   <= '0;
      original_total  <= '0;
    end else if (cmd.update) begin
      if (found) begin
        duplicate_total <= duplicate_total + 1'b1;
      end else begin
        original_total <= original_total + 1'b1;
        if (gap) begin
          missing_total <= missing_total + CNT_W'(diff - 1'b1);
        end
        if (full) begin
          oldest_slot <= oldest_slot + 1'b1;
        end else begin
          fill_level <= fill_level + 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/swldc_checker.sv
// port-level assertions for the sequence window checker, bound to its top level
// depends on swldc_pkg and the assertion macro header
`include "sequence_window_loss_dup_checker_unit_assert.svh"

module swldc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [swldc_pkg::SEQ_W-1:0] seq_number,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        dup_flag,
  input logic                        gap_flag,
  input logic [swldc_pkg::SEQ_W-1:0] gap_start,
  input logic [swldc_pkg::SEQ_W-1:0] gap_end,
  input logic [swldc_pkg::CNT_W-1:0] duplicate_total,
  input logic [swldc_pkg::CNT_W-1:0] missing_total,
  input logic [swldc_pkg::CNT_W-1:0] original_total
);

  import swldc_pkg::*;

  logic [SEQ_W-1:0]               gap_span;
  logic                           in_seen;
  logic                           gap_ok;
  logic [2*SEQ_W+3*CNT_W+1:0]     out_word;

  assign gap_span = gap_end - gap_start;
  assign in_seen  = in_valid || in_stall || (seq_number != seq_number);
  assign out_word = {dup_flag, gap_flag, gap_start, gap_end,
                     duplicate_total, missing_total, original_total};

  // gap bounds are zero without a gap and span less than half the range with one
  assign gap_ok = (gap_flag && (gap_span < HALF_RANGE)) ||
                  (!gap_flag && (gap_start == '0) && (gap_end == '0));

  // a stalled result word holds
  `SWLDC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))

  // a duplicate never reveals a gap
  `SWLDC_ASSERT_IMPLY(a_dup_no_gap, clk, rst, out_valid && dup_flag, !gap_flag)

  // gap fields consistent with the gap flag
  `SWLDC_ASSERT_IMPLY(a_gap_range, clk, rst, out_valid, gap_ok)

  // one word is either a duplicate or an original, never both
  `SWLDC_ASSERT_IMPLY(a_one_count, clk, rst, !$past(rst) && in_seen, $stable(duplicate_total) || $stable(original_total))

endmodule

bind sequence_window_loss_dup_checker_unit swldc_checker u_swldc_checker (.*);
